[hdl/slm_pkg.sv]
// Shared types, constants and helpers for the stereo audio level monitor.
package slm_pkg;

   // Width of the saturating frame counter.
   localparam int COUNT_WIDTH = 32;

   localparam int WORD_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int SQUARE_W = 31;   // (-32768)^2 = 2^30 needs 31 bits
   localparam int SUM_W    = 48;
   localparam int SQSUM_W  = 63;
   localparam int EVENT_W  = 32;
   localparam int PEAK_W   = 16;
   localparam int SEEN_W   = 32;

   localparam logic [0:0] KIND_FRAME  = 1'b0;
   localparam logic [0:0] KIND_REPORT = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   localparam logic [SUM_W-1:0]   SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]   SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [SQSUM_W-1:0] SQSUM_MAX   = {SQSUM_W{1'b1}};
   localparam logic [EVENT_W-1:0] EVENT_MAX   = {EVENT_W{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] FRAME_MAX = {COUNT_WIDTH{1'b1}};

   // Captured item: extracted samples plus the precomputed square.
   typedef struct packed {
      logic [0:0]          kind;
      sample_type          left;
      sample_type          right;
      logic [SQUARE_W-1:0] square;
   } front_data_type;

   // Saturating increment for the event counters.
   function automatic logic [EVENT_W-1:0] bump(input logic [EVENT_W-1:0] c);
      bump = (c == EVENT_MAX) ? c : c + EVENT_W'(1);
   endfunction

endpackage

[hdl/slm_if.sv]
// Valid/ready channel interfaces for the request and response streams.
interface slm_req_if
   import slm_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [0:0]               kind;
   logic signed [WORD_W-1:0] left_word;
   logic signed [WORD_W-1:0] right_word;

   modport source (output valid, output kind, output left_word, output right_word,
                   input ready);
   modport sink   (input valid, input kind, input left_word, input right_word,
                   output ready);
endinterface

interface slm_rsp_if
   import slm_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [SEEN_W-1:0]    frames_seen;
   logic signed [SUM_W-1:0] left_sum;
   logic [SQSUM_W-1:0]   left_square_sum;
   logic [PEAK_W-1:0]    peak_level;
   logic [EVENT_W-1:0]   clip_count;
   logic [EVENT_W-1:0]   mismatch_count;
   logic [EVENT_W-1:0]   crossing_count;
   logic                 overflowed;

   modport source (output valid, output frames_seen, output left_sum,
                   output left_square_sum, output peak_level, output clip_count,
                   output mismatch_count, output crossing_count, output overflowed,
                   input ready);
   modport sink   (input valid, input frames_seen, input left_sum,
                   input left_square_sum, input peak_level, input clip_count,
                   input mismatch_count, input crossing_count, input overflowed,
                   output ready);
endinterface

[hdl/slm_front.sv]
// Input register: sample extraction and left-sample square.
module slm_front
   import slm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   slm_req_if.sink        req_bus,
   input  logic           advance,
   output logic           stage_valid,
   output front_data_type stage_data
);

   logic           valid_ff, valid_in;
   front_data_type data_ff, data_in;
   sample_type     left_s;
   sample_type     right_s;
   logic signed [2*SAMPLE_W-1:0] product;

   assign req_bus.ready = !valid_ff || advance;

   always_comb begin
      left_s  = req_bus.left_word[WORD_W-1:WORD_W-SAMPLE_W];
      right_s = req_bus.right_word[WORD_W-1:WORD_W-SAMPLE_W];
      product = left_s * left_s;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_bus.ready) begin
         valid_in = req_bus.valid;
         data_in.kind   = req_bus.kind;
         data_in.left   = left_s;
         data_in.right  = right_s;
         data_in.square = product[SQUARE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

[hdl/slm_accum.sv]
// Statistics state, per-item update and result register.
module slm_accum
   import slm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           stage_valid,
   input  front_data_type stage_data,
   output logic           advance,
   slm_rsp_if.source      rsp_bus
);

   // statistics state
   sample_type              prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0]  frames_ff, frames_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SQSUM_W-1:0]      sqsum_ff, sqsum_in;
   logic [PEAK_W-1:0]       peak_ff, peak_in;
   logic [EVENT_W-1:0]      clip_ff, clip_in;
   logic [EVENT_W-1:0]      mismatch_ff, mismatch_in;
   logic [EVENT_W-1:0]      crossing_ff, crossing_in;
   logic                    ovf_ff, ovf_in;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic [SEEN_W-1:0]       r_frames_ff, r_frames_in;
   logic [SUM_W-1:0]        r_sum_ff, r_sum_in;
   logic [SQSUM_W-1:0]      r_sqsum_ff, r_sqsum_in;
   logic [PEAK_W-1:0]       r_peak_ff, r_peak_in;
   logic [EVENT_W-1:0]      r_clip_ff, r_clip_in;
   logic [EVENT_W-1:0]      r_mismatch_ff, r_mismatch_in;
   logic [EVENT_W-1:0]      r_crossing_ff, r_crossing_in;
   logic                    r_ovf_ff, r_ovf_in;

   logic                    take;
   logic signed [SAMPLE_W:0] left_x;
   logic signed [SAMPLE_W:0] mag;
   logic [SUM_W:0]          sum_wide;
   logic [SQSUM_W:0]        sq_wide;
   logic [COUNT_WIDTH+SEEN_W-1:0] seen_ext;
   logic [COUNT_WIDTH+SEEN_W-1:0] seen_ext_ff;
   logic                    prev_nonpos;
   logic                    left_pos;

   assign advance = !out_valid_ff || rsp_bus.ready;
   assign take    = stage_valid && advance;

   always_comb begin
      left_x   = {stage_data.left[SAMPLE_W-1], stage_data.left};
      mag      = left_x[SAMPLE_W] ? -left_x : left_x;
      sum_wide = {sum_ff[SUM_W-1], sum_ff}
               + {{(SUM_W-SAMPLE_W+1){stage_data.left[SAMPLE_W-1]}}, stage_data.left};
      sq_wide  = {1'b0, sqsum_ff} + {{(SQSUM_W-SQUARE_W+1){1'b0}}, stage_data.square};
      prev_nonpos = prev_ff[SAMPLE_W-1] || (prev_ff == '0);
      left_pos    = !stage_data.left[SAMPLE_W-1] && (stage_data.left != '0);

      prev_in     = prev_ff;
      frames_in   = frames_ff;
      sum_in      = sum_ff;
      sqsum_in    = sqsum_ff;
      peak_in     = peak_ff;
      clip_in     = clip_ff;
      mismatch_in = mismatch_ff;
      crossing_in = crossing_ff;
      ovf_in      = ovf_ff;

      if (take && stage_data.kind == KIND_FRAME) begin
         if (frames_ff == FRAME_MAX) begin
            ovf_in = 1'b1;
         end else begin
            frames_in = frames_ff + COUNT_WIDTH'(1);
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
               sum_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
               sum_in = sum_wide[SUM_W-1:0];
            end
            sqsum_in = sq_wide[SQSUM_W] ? SQSUM_MAX : sq_wide[SQSUM_W-1:0];
            if (mag[PEAK_W-1:0] > peak_ff) begin
               peak_in = mag[PEAK_W-1:0];
            end
            if (stage_data.left == SAMPLE_MIN || stage_data.left == SAMPLE_MAX) begin
               clip_in = bump(clip_ff);
            end
            if (stage_data.left != stage_data.right) begin
               mismatch_in = bump(mismatch_ff);
            end
            if (prev_nonpos && left_pos) begin
               crossing_in = bump(crossing_ff);
            end
            prev_in = stage_data.left;
         end
      end
   end

   // Result: updated totals for a frame, pre-clear totals for a report.
   always_comb begin
      seen_ext    = {{SEEN_W{1'b0}}, frames_in};
      seen_ext_ff = {{SEEN_W{1'b0}}, frames_ff};
      out_valid_in  = advance ? stage_valid : out_valid_ff;
      r_frames_in   = r_frames_ff;
      r_sum_in      = r_sum_ff;
      r_sqsum_in    = r_sqsum_ff;
      r_peak_in     = r_peak_ff;
      r_clip_in     = r_clip_ff;
      r_mismatch_in = r_mismatch_ff;
      r_crossing_in = r_crossing_ff;
      r_ovf_in      = r_ovf_ff;
      if (take) begin
         if (stage_data.kind == KIND_REPORT) begin
            r_frames_in   = seen_ext_ff[SEEN_W-1:0];
            r_sum_in      = sum_ff;
            r_sqsum_in    = sqsum_ff;
            r_peak_in     = peak_ff;
            r_clip_in     = clip_ff;
            r_mismatch_in = mismatch_ff;
            r_crossing_in = crossing_ff;
            r_ovf_in      = ovf_ff;
         end else begin
            r_frames_in   = seen_ext[SEEN_W-1:0];
            r_sum_in      = sum_in;
            r_sqsum_in    = sqsum_in;
            r_peak_in     = peak_in;
            r_clip_in     = clip_in;
            r_mismatch_in = mismatch_in;
            r_crossing_in = crossing_in;
            r_ovf_in      = ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         frames_ff    <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         peak_ff      <= '0;
         clip_ff      <= '0;
         mismatch_ff  <= '0;
         crossing_ff  <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
         if (take && stage_data.kind == KIND_REPORT) begin
            // clear totals; previous sample survives
            frames_ff   <= '0;
            sum_ff      <= '0;
            sqsum_ff    <= '0;
            peak_ff     <= '0;
            clip_ff     <= '0;
            mismatch_ff <= '0;
            crossing_ff <= '0;
            ovf_ff      <= 1'b0;
         end else begin
            frames_ff   <= frames_in;
            sum_ff      <= sum_in;
            sqsum_ff    <= sqsum_in;
            peak_ff     <= peak_in;
            clip_ff     <= clip_in;
            mismatch_ff <= mismatch_in;
            crossing_ff <= crossing_in;
            ovf_ff      <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_frames_ff   <= r_frames_in;
      r_sum_ff      <= r_sum_in;
      r_sqsum_ff    <= r_sqsum_in;
      r_peak_ff     <= r_peak_in;
      r_clip_ff     <= r_clip_in;
      r_mismatch_ff <= r_mismatch_in;
      r_crossing_ff <= r_crossing_in;
      r_ovf_ff      <= r_ovf_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.frames_seen     = r_frames_ff;
   assign rsp_bus.left_sum        = r_sum_ff;
   assign rsp_bus.left_square_sum = r_sqsum_ff;
   assign rsp_bus.peak_level      = r_peak_ff;
   assign rsp_bus.clip_count      = r_clip_ff;
   assign rsp_bus.mismatch_count  = r_mismatch_ff;
   assign rsp_bus.crossing_count  = r_crossing_ff;
   assign rsp_bus.overflowed      = r_ovf_ff;

endmodule

[hdl/stereo_audio_level_monitor.sv]
// Stereo audio level monitor: top level.
// Path: a request transfer enters the input register, its response the result register.
// Throughput: one item per cycle unless the response stalls; the input and result
//   registers each hold one item, so a stalled response still lets one more request in.
// Reset (synchronous, active high) zeroes every total, the previous left
//   sample and both valid flags.
module stereo_audio_level_monitor
   import slm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   slm_req_if.sink   req_bus,
   slm_rsp_if.source rsp_bus
);

   // front stage -> accumulator
   logic           stage_valid;
   front_data_type stage_data;
   // accumulator can take the front item this cycle
   logic           advance;

   // Stage 1: capture samples, square the left one.
   slm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   // Stage 2: update the running totals and register the response.
   slm_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .advance     (advance),
      .rsp_bus     (rsp_bus)
   );

endmodule
